### rtl/fwbc_pkg.sv
`default_nettype none

package fwbc_pkg;

	// number of slots in the cell row
	localparam int SLOTS = 16;

	// index width into the cell row, never below one bit
	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	// field widths
	localparam int TAG_W  = 16;
	localparam int SLOT_W = 6;
	localparam int CNT_W  = 7;
	localparam int FUNC_W = 2;

	// slot count after reset
	localparam logic [CNT_W-1:0] SLOTS_RST = 7'd16;

	// request function codes
	localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_FLUSH = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_INVAL = 2'd2;

	// register indexes
	localparam logic REG_ENABLE = 1'b0;
	localparam logic REG_SLOTS  = 1'b1;

	// control broadcast from the sequencer to every cell
	typedef struct packed {
		logic             scan;   // token picks the selected cell
		logic             start;  // load pending flags, token into cell 0
		logic             adv;    // token moves one cell on
		logic             wr;     // fill the head cell with blk
		logic             inval;  // clear every valid bit
		logic [CNT_W-1:0] n;      // effective slot count
		logic [IDX_W-1:0] head;   // slot selected outside a scan
		logic [TAG_W-1:0] blk;    // block number under compare
	} ctl_t;

	// status returned by each cell, or-reduced over the row
	typedef struct packed {
		logic             v_en;      // valid and in range
		logic             match;     // valid, in range, tag equal
		logic             others;    // pending and not holding the token
		logic             sel_valid; // selected and valid
		logic             sel_pend;  // selected and pending
		logic [TAG_W-1:0] sel_tag;   // tag of a selected valid cell, else zero
		logic [IDX_W-1:0] sel_idx;   // index of the selected cell, else zero
	} stat_t;

endpackage

`default_nettype wire

### rtl/fwbc_cell.sv
`default_nettype none

module fwbc_cell (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire [fwbc_pkg::IDX_W-1:0] idx,
	input  fwbc_pkg::ctl_t           ctl,
	input  wire                      tok_in,
	output logic                     tok_out,
	output fwbc_pkg::stat_t          stat
);

	logic                       valid_q;
	logic [fwbc_pkg::TAG_W-1:0] tag_q;
	logic                       pend_q;
	logic                       tok_q;
	logic                       en;
	logic                       sel;
	logic                       wr_me;

	// slot lies inside the count in use
	assign en    = fwbc_pkg::CNT_W'(idx) < ctl.n;
	assign sel   = ctl.scan ? tok_q : (idx == ctl.head);
	assign wr_me = ctl.wr && (idx == ctl.head);

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.inval) begin
			valid_q <= 1'b0;
		end else if (wr_me) begin
			valid_q <= 1'b1;
		end
	end

	// tag store, undefined until first fill
	always_ff @(posedge clk) begin
		if (wr_me) begin
			tag_q <= ctl.blk;
		end
	end

	// pending flag for a flush or invalidate walk, token handed along the row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			tok_q  <= 1'b0;
		end else if (ctl.start) begin
			pend_q <= valid_q & en;
			tok_q  <= (idx == '0);
		end else if (ctl.adv) begin
			if (tok_q) begin
				pend_q <= 1'b0;
			end
			tok_q <= tok_in;
		end
	end

	assign tok_out = tok_q;

	// status to the sequencer
	always_comb begin
		stat.v_en      = valid_q & en;
		stat.match     = valid_q & en & (tag_q == ctl.blk);
		stat.others    = pend_q & ~tok_q;
		stat.sel_valid = sel & valid_q;
		stat.sel_pend  = sel & pend_q;
		stat.sel_tag   = (sel & valid_q) ? tag_q : '0;
		stat.sel_idx   = sel ? idx : '0;
	end

endmodule

`default_nettype wire

### rtl/fifo_write_back_block_cache_top.sv
`default_nettype none

// channel  | direction | accepted when        | contents
// s_       | in        | s_tvalid & s_tready  | request: func, block number
// m_       | out       | m_tvalid & m_tready  | result: slot, write-back tag, flags
// apb      | in        | psel&penable&pwrite  | cache_enable, slots_in_use
//
// a write request: accept, then tag compare and result load once m_ is free
// flush and invalidate walk a token along the cell row up to the highest valid
// in-range slot, one cell a cycle unless a stalled result holds it
// requests with no result end at accept
// the block holds one request at a time; a stalled result holds the walk
// reset clears all valid bits at once, tags stay undefined until filled

module fifo_write_back_block_cache_top (
	input  wire        clk,
	input  wire        arst_n,
	// request in
	input  wire        s_tvalid,
	output logic       s_tready,
	input  wire [15:0] s_tdata,  // [15:0] blk_num
	input  wire [1:0]  s_tuser,  // [1:0] func
	// result out
	output logic       m_tvalid,
	input  wire        m_tready,
	output logic [23:0] m_tdata, // [5:0] slot, [21:6] writeback_block, [23:22] zero
	output logic [2:0] m_tuser,  // [0] bypass, [1] hit, [2] writeback
	output logic       m_tlast,
	// configuration
	input  wire        psel,
	input  wire        penable,
	input  wire        pwrite,
	input  wire [2:0]  paddr,
	input  wire [31:0] pwdata,
	output logic [31:0] prdata,
	output logic       pready
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WR   = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;

	logic [1:0]                      state_q;
	logic [fwbc_pkg::FUNC_W-1:0]     func_q;
	logic [fwbc_pkg::TAG_W-1:0]      blk_q;
	logic [fwbc_pkg::IDX_W-1:0]      head_q;
	logic                            enable_q;
	logic [fwbc_pkg::CNT_W-1:0]      slots_q;

	logic                            mv_q;
	logic                            byp_q;
	logic                            hit_q;
	logic                            wb_q;
	logic [fwbc_pkg::SLOT_W-1:0]     slot_q;
	logic [fwbc_pkg::TAG_W-1:0]      wbb_q;
	logic                            last_q;

	fwbc_pkg::ctl_t                  ctl;
	fwbc_pkg::stat_t                 st [fwbc_pkg::SLOTS];
	logic [fwbc_pkg::SLOTS:0]        tok;
	logic [fwbc_pkg::SLOTS-1:0]      match_vec;
	logic [fwbc_pkg::SLOTS-1:0]      ven_vec;
	logic [fwbc_pkg::SLOTS-1:0]      tok_vec;

	logic                            any_match;
	logic                            any_ven;
	logic                            others;
	logic                            sel_valid;
	logic                            sel_pend;
	logic [fwbc_pkg::TAG_W-1:0]      sel_tag;
	logic [fwbc_pkg::IDX_W-1:0]      sel_idx;
	logic [fwbc_pkg::IDX_W-1:0]      hit_idx;

	logic [fwbc_pkg::CNT_W-1:0]      n_eff;
	logic [fwbc_pkg::IDX_W-1:0]      h;
	logic [fwbc_pkg::CNT_W-1:0]      hp1;
	logic [fwbc_pkg::IDX_W-1:0]      head_nxt;

	logic                            s_acc;
	logic                            out_free;
	logic                            cfg_wr;

	// configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			slots_q  <= fwbc_pkg::SLOTS_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				fwbc_pkg::REG_ENABLE: enable_q <= pwdata[0];
				fwbc_pkg::REG_SLOTS:  slots_q  <= pwdata[fwbc_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			fwbc_pkg::REG_ENABLE: prdata = {31'd0, enable_q};
			fwbc_pkg::REG_SLOTS:  prdata = {{(32 - fwbc_pkg::CNT_W){1'b0}}, slots_q};
			default:              prdata = '0;
		endcase
	end

	// effective count and fifo head
	always_comb begin
		if (slots_q == '0) begin
			n_eff = fwbc_pkg::CNT_W'(1);
		end else if (slots_q > fwbc_pkg::CNT_W'(fwbc_pkg::SLOTS)) begin
			n_eff = fwbc_pkg::CNT_W'(fwbc_pkg::SLOTS);
		end else begin
			n_eff = slots_q;
		end
		h        = (fwbc_pkg::CNT_W'(head_q) < n_eff) ? head_q : '0;
		hp1      = fwbc_pkg::CNT_W'(h) + fwbc_pkg::CNT_W'(1);
		head_nxt = (hp1 == n_eff) ? '0 : hp1[fwbc_pkg::IDX_W-1:0];
	end

	// row of cells
	assign tok[0] = 1'b0;

	for (genvar i = 0; i < fwbc_pkg::SLOTS; i++) begin : g_cell
		fwbc_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.idx     (fwbc_pkg::IDX_W'(i)),
			.ctl     (ctl),
			.tok_in  (tok[i]),
			.tok_out (tok[i+1]),
			.stat    (st[i])
		);
		assign match_vec[i] = st[i].match;
		assign ven_vec[i]   = st[i].v_en;
		assign tok_vec[i]   = tok[i+1];
	end

	// reduce the cell status
	always_comb begin
		others    = 1'b0;
		sel_valid = 1'b0;
		sel_pend  = 1'b0;
		sel_tag   = '0;
		sel_idx   = '0;
		for (int i = 0; i < fwbc_pkg::SLOTS; i++) begin
			others    = others | st[i].others;
			sel_valid = sel_valid | st[i].sel_valid;
			sel_pend  = sel_pend | st[i].sel_pend;
			sel_tag   = sel_tag | st[i].sel_tag;
			sel_idx   = sel_idx | st[i].sel_idx;
		end
	end

	assign any_match = |match_vec;
	assign any_ven   = |ven_vec;

	// lowest matching slot wins
	always_comb begin
		hit_idx = '0;
		for (int i = fwbc_pkg::SLOTS - 1; i >= 0; i--) begin
			if (match_vec[i]) begin
				hit_idx = fwbc_pkg::IDX_W'(i);
			end
		end
	end

	// handshake
	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid & s_tready;
	assign out_free = ~mv_q | m_tready;

	// sequencer control to the cells
	always_comb begin
		ctl.scan  = (state_q == ST_SCAN);
		ctl.start = 1'b0;
		ctl.adv   = 1'b0;
		ctl.wr    = 1'b0;
		ctl.inval = 1'b0;
		ctl.n     = n_eff;
		ctl.head  = h;
		ctl.blk   = blk_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_acc && enable_q &&
				    (s_tuser == fwbc_pkg::FUNC_FLUSH || s_tuser == fwbc_pkg::FUNC_INVAL)) begin
					if (any_ven) begin
						ctl.start = 1'b1;
					end else if (s_tuser == fwbc_pkg::FUNC_INVAL) begin
						ctl.inval = 1'b1;
					end
				end
			end
			ST_WR: begin
				ctl.wr = out_free & enable_q & ~any_match;
			end
			ST_SCAN: begin
				ctl.adv = ~sel_pend | out_free;
				ctl.inval = sel_pend & out_free & ~others &
				            (func_q == fwbc_pkg::FUNC_INVAL);
			end
			default: ;
		endcase
	end

	// state, request and head registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			func_q  <= fwbc_pkg::FUNC_WRITE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						func_q <= s_tuser;
						if (s_tuser == fwbc_pkg::FUNC_WRITE) begin
							state_q <= ST_WR;
						end else if (ctl.start) begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_WR: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					if (sel_pend && out_free && !others) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (ctl.inval) begin
				head_q <= '0;
			end else if (ctl.wr) begin
				head_q <= head_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			blk_q <= s_tdata;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mv_q <= 1'b0;
		end else if ((state_q == ST_WR && out_free) ||
		             (state_q == ST_SCAN && sel_pend && out_free)) begin
			mv_q <= 1'b1;
		end else if (m_tready) begin
			mv_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_WR && out_free) begin
			last_q <= 1'b1;
			if (!enable_q) begin
				byp_q  <= 1'b1;
				hit_q  <= 1'b0;
				wb_q   <= 1'b0;
				slot_q <= '0;
				wbb_q  <= '0;
			end else if (any_match) begin
				byp_q  <= 1'b0;
				hit_q  <= 1'b1;
				wb_q   <= 1'b0;
				slot_q <= fwbc_pkg::SLOT_W'(hit_idx);
				wbb_q  <= '0;
			end else begin
				byp_q  <= 1'b0;
				hit_q  <= 1'b0;
				wb_q   <= sel_valid;
				slot_q <= fwbc_pkg::SLOT_W'(h);
				wbb_q  <= sel_tag;
			end
		end else if (state_q == ST_SCAN && sel_pend && out_free) begin
			byp_q  <= 1'b0;
			hit_q  <= 1'b0;
			wb_q   <= 1'b1;
			slot_q <= fwbc_pkg::SLOT_W'(sel_idx);
			wbb_q  <= sel_tag;
			last_q <= ~others;
		end
	end

	assign m_tvalid = mv_q;
	assign m_tdata  = {2'b00, wbb_q, slot_q};
	assign m_tuser  = {wb_q, hit_q, byp_q};
	assign m_tlast  = last_q;

	// at most one cell holds the token
	a_tok_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_vec))
		else $error("token held by more than one cell");

	// invalidate leaves no valid slot in range
	a_inval_empty: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.inval |=> (ven_vec == '0))
		else $error("valid slot left after invalidate");

	// a hit never names a write-back or a bypass
	a_hit_no_wb: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[1]) |-> (!m_tuser[2] && !m_tuser[0]))
		else $error("hit result with write-back or bypass");

	// a fill only happens on a write miss with a result slot free
	a_fill_ctx: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.wr |-> (state_q == ST_WR && out_free && !any_match))
		else $error("fill outside a write miss");

endmodule

`default_nettype wire
